>>> rtl/slab_free_list_allocator_macros.svh
// ----------------------------------------------------------------------------
// slab_free_list_allocator_macros.svh
// Assertion shorthands shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef SLAB_FREE_LIST_ALLOCATOR_MACROS_SVH
`define SLAB_FREE_LIST_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define SFLA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// next-cycle implication, disabled while reset is held
`define SFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

>>> rtl/sfla_pkg.sv
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared types and codes for the slab free-list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 10;
    localparam int DOUT_W  = 64;
    localparam int STAT_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_RANGE  = 2'd2,
        ST_VACANT = 2'd3
    } t_status;

    typedef struct packed {
        t_status           status;
        logic [IDX_W-1:0]  index;
        logic [DOUT_W-1:0] data;
    } t_result;

endpackage

>>> rtl/sfla_store.sv
// ----------------------------------------------------------------------------
// sfla_store
// Slot memory: value, free-list link and occupied flag per entry.
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sfla_store #(
    parameter int AW = 10,
    parameter int CW = 11,
    parameter int DW = 64,
    parameter int DEPTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic          i_wr_occ,
    input  logic [CW-1:0] i_wr_link,
    input  logic [DW-1:0] i_wr_value,
    output logic          o_rd_occ,
    output logic [CW-1:0] o_rd_link,
    output logic [DW-1:0] o_rd_value
);

    localparam int WORD_W = 1 + CW + DW;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_word;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_occ, i_wr_link, i_wr_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_word <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_occ   = r_rd_word[WORD_W-1];
    assign o_rd_link  = r_rd_word[CW+DW-1:DW];
    assign o_rd_value = r_rd_word[DW-1:0];

endmodule

>>> rtl/sfla_ctrl.sv
// ----------------------------------------------------------------------------
// sfla_ctrl
// Request sequencer: issues the slot read on accept, then checks, updates
// the free list and writes back in the following cycle.
// ----------------------------------------------------------------------------
`include "slab_free_list_allocator_macros.svh"

module sfla_ctrl #(
    parameter int CAPACITY = 1024,
    parameter int AW = 10,
    parameter int CW = 11,
    parameter int DW = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [sfla_pkg::CMD_W-1:0]  i_command,
    input  logic [sfla_pkg::IDX_W-1:0]  i_slot_index,
    input  logic [sfla_pkg::DOUT_W-1:0] i_data_in,
    // memory side
    output logic                        o_rd_en,
    output logic [AW-1:0]               o_rd_addr,
    output logic                        o_wr_en,
    output logic [AW-1:0]               o_wr_addr,
    output logic                        o_wr_occ,
    output logic [CW-1:0]               o_wr_link,
    output logic [DW-1:0]               o_wr_value,
    input  logic                        i_rd_occ,
    input  logic [CW-1:0]               i_rd_link,
    input  logic [DW-1:0]               i_rd_value,
    // result side
    output logic                        o_valid,
    output sfla_pkg::t_result           o_result
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                       r_state, n_state;
    sfla_pkg::t_cmd               r_cmd;
    logic [sfla_pkg::IDX_W-1:0]   r_idx;
    logic [DW-1:0]                r_data;
    logic [CW-1:0]                r_free_head, n_free_head;
    logic [CW-1:0]                r_used, n_used;
    logic                         r_valid, n_valid;
    sfla_pkg::t_result            r_res, n_res;

    logic                         accept;
    logic [31:0]                  in_idx32, r_idx32, slot32;
    logic [CW-1:0]                head_m1;
    logic [AW-1:0]                head_slot, used_slot, req_slot, ins_slot;
    logic                         in_range;

    assign busy   = (r_state == S_EXEC);
    assign accept = start && !busy;

    assign in_idx32  = 32'(i_slot_index);
    assign r_idx32   = 32'(r_idx);
    assign head_m1   = r_free_head - CW'(1);
    assign head_slot = head_m1[AW-1:0];
    assign used_slot = r_used[AW-1:0];
    assign req_slot  = r_idx32[AW-1:0];
    assign in_range  = r_idx32 < 32'(r_used);

    // read the head link for insert, the addressed slot otherwise
    assign o_rd_en   = accept;
    assign o_rd_addr = (sfla_pkg::t_cmd'(i_command) == sfla_pkg::CMD_INSERT)
                       ? head_slot : in_idx32[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_free_head = r_free_head;
        n_used      = r_used;
        n_valid     = 1'b0;
        n_res       = r_res;
        o_wr_en     = 1'b0;
        o_wr_addr   = req_slot;
        o_wr_occ    = 1'b0;
        o_wr_link   = r_free_head;
        o_wr_value  = i_rd_value;
        ins_slot    = used_slot;
        slot32      = 32'(used_slot);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state      = S_IDLE;
                n_valid      = 1'b1;
                n_res.status = sfla_pkg::ST_OK;
                n_res.index  = r_idx;
                n_res.data   = '0;
                unique case (r_cmd)
                    sfla_pkg::CMD_INSERT: begin
                        if (r_free_head != '0) begin
                            ins_slot    = head_slot;
                            n_free_head = i_rd_link;
                        end else if (r_used < CW'(CAPACITY)) begin
                            ins_slot = used_slot;
                            n_used   = r_used + CW'(1);
                        end else begin
                            n_res.status = sfla_pkg::ST_FULL;
                        end
                        slot32 = 32'(ins_slot);
                        if (n_res.status == sfla_pkg::ST_OK) begin
                            o_wr_en     = 1'b1;
                            o_wr_addr   = ins_slot;
                            o_wr_occ    = 1'b1;
                            o_wr_link   = '0;
                            o_wr_value  = r_data;
                            n_res.index = slot32[sfla_pkg::IDX_W-1:0];
                        end
                    end
                    sfla_pkg::CMD_REMOVE, sfla_pkg::CMD_GET: begin
                        if (!in_range) begin
                            n_res.status = sfla_pkg::ST_RANGE;
                        end else if (!i_rd_occ) begin
                            n_res.status = sfla_pkg::ST_VACANT;
                        end else if (r_cmd == sfla_pkg::CMD_GET) begin
                            n_res.data = sfla_pkg::DOUT_W'(i_rd_value);
                        end else begin
                            // push the slot onto the free list
                            o_wr_en     = 1'b1;
                            o_wr_addr   = req_slot;
                            o_wr_occ    = 1'b0;
                            o_wr_link   = r_free_head;
                            o_wr_value  = i_rd_value;
                            n_free_head = CW'(req_slot) + CW'(1);
                        end
                    end
                    sfla_pkg::CMD_NONE: begin
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_used      <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_used      <= n_used;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= sfla_pkg::t_cmd'(i_command);
            r_idx  <= i_slot_index;
            r_data <= i_data_in[DW-1:0];
        end
        r_res <= n_res;
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    `SFLA_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, accept, r_state == S_EXEC)
    `SFLA_ASSERT_NEXT(a_exec_gives_result, i_clk, i_rst_n, r_state == S_EXEC, r_valid)
    `SFLA_ASSERT_IMPL(a_write_in_exec, i_clk, i_rst_n, o_wr_en, r_state == S_EXEC)
    `SFLA_ASSERT_IMPL(a_used_bounded, i_clk, i_rst_n, 1'b1, 32'(r_used) <= 32'(CAPACITY))
    `SFLA_ASSERT_IMPL(a_head_bounded, i_clk, i_rst_n, r_free_head != '0,
                      32'(r_free_head) <= 32'(r_used))

endmodule

>>> rtl/slab_free_list_allocator.sv
// ----------------------------------------------------------------------------
// slab_free_list_allocator
// Slot store with a free list threaded through vacant entries.
// Timing: result strobe high in the cycle after the write-back edge; busy is
//   high for one cycle, holding off a new request until the write-back,
//   set by the read-then-write of the slot memory with its registered read
//   data.
// Reset: synchronous; empties the free list and the used count, memory
//   contents are left as they are. Results cannot be stalled.
// ----------------------------------------------------------------------------
module slab_free_list_allocator #(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [sfla_pkg::CMD_W-1:0]  i_command,
    input  logic [sfla_pkg::IDX_W-1:0]  i_slot_index,
    input  logic [sfla_pkg::DOUT_W-1:0] i_data_in,
    output logic                        o_valid,
    output logic [sfla_pkg::STAT_W-1:0] o_status,
    output logic [sfla_pkg::IDX_W-1:0]  o_result_index,
    output logic [sfla_pkg::DOUT_W-1:0] o_data_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                  rd_en, wr_en, wr_occ, rd_occ;
    logic [AW-1:0]         rd_addr, wr_addr;
    logic [CW-1:0]         wr_link, rd_link;
    logic [DATA_WIDTH-1:0] wr_value, rd_value;
    sfla_pkg::t_result     result;

    sfla_store #(
        .AW    (AW),
        .CW    (CW),
        .DW    (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk      (i_clk),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_occ   (wr_occ),
        .i_wr_link  (wr_link),
        .i_wr_value (wr_value),
        .o_rd_occ   (rd_occ),
        .o_rd_link  (rd_link),
        .o_rd_value (rd_value)
    );

    sfla_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW),
        .DW       (DATA_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_slot_index (i_slot_index),
        .i_data_in    (i_data_in),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_occ     (wr_occ),
        .o_wr_link    (wr_link),
        .o_wr_value   (wr_value),
        .i_rd_occ     (rd_occ),
        .i_rd_link    (rd_link),
        .i_rd_value   (rd_value),
        .o_valid      (o_valid),
        .o_result     (result)
    );

    assign o_status       = result.status;
    assign o_result_index = result.index;
    assign o_data_out     = result.data;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the slab free-list allocator. A directed table walks
// reset state, range and vacancy errors and free-list reuse; random traffic of
// mostly well-formed insert/remove/get requests follows, then the store is
// filled to capacity and exercised while full. Every result is compared with
// the table's expectation or an in-bench model of the slot store and free list.
// ----------------------------------------------------------------------------
module tb;

    localparam int CAPACITY    = 1024;
    localparam int DATA_WIDTH  = 64;
    localparam int IDLE_LIMIT  = 1000;

    typedef struct {
        sfla_pkg::t_cmd              cmd;
        logic [sfla_pkg::IDX_W-1:0]  idx;
        logic [sfla_pkg::DOUT_W-1:0] data;
        bit                          typed;
        sfla_pkg::t_result           exp;
    } t_stim_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [sfla_pkg::CMD_W-1:0]    i_command;
    logic [sfla_pkg::IDX_W-1:0]    i_slot_index;
    logic [sfla_pkg::DOUT_W-1:0]   i_data_in;
    logic                          o_valid;
    logic [sfla_pkg::STAT_W-1:0]   o_status;
    logic [sfla_pkg::IDX_W-1:0]    o_result_index;
    logic [sfla_pkg::DOUT_W-1:0]   o_data_out;

    // model of the slot store
    logic [sfla_pkg::DOUT_W-1:0]   slot_data [CAPACITY];
    int                            slot_next [CAPACITY];
    bit                            slot_live [CAPACITY];
    int                            free_top;
    int                            slots_used;

    sfla_pkg::t_result             pending_results [$];
    t_stim_row                     directed_rows [$];
    int                            fail_count;
    int                            idle_cycles;
    bit                            no_gap;

    slab_free_list_allocator #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_slot_index   (i_slot_index),
        .i_data_in      (i_data_in),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_result_index (o_result_index),
        .o_data_out     (o_data_out)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic sfla_pkg::t_result allocate_or_lookup(
        sfla_pkg::t_cmd cmd, logic [sfla_pkg::IDX_W-1:0] idx,
        logic [sfla_pkg::DOUT_W-1:0] data);
        sfla_pkg::t_result r;
        int                slot;
        r.status = sfla_pkg::ST_OK;
        r.index  = idx;
        r.data   = '0;
        case (cmd)
            sfla_pkg::CMD_INSERT: begin
                slot = -1;
                if (free_top != 0) begin
                    slot     = free_top - 1;
                    free_top = slot_next[slot];
                end else if (slots_used < CAPACITY) begin
                    slot = slots_used;
                    slots_used++;
                end
                if (slot < 0) begin
                    r.status = sfla_pkg::ST_FULL;
                end else begin
                    slot_data[slot] = data;
                    slot_live[slot] = 1'b1;
                    r.index         = sfla_pkg::IDX_W'(slot);
                end
            end
            sfla_pkg::CMD_REMOVE, sfla_pkg::CMD_GET: begin
                if (int'(idx) >= slots_used) begin
                    r.status = sfla_pkg::ST_RANGE;
                end else if (!slot_live[idx]) begin
                    r.status = sfla_pkg::ST_VACANT;
                end else if (cmd == sfla_pkg::CMD_GET) begin
                    r.data = slot_data[idx];
                end else begin
                    // vacated slot becomes the new free-list head
                    slot_live[idx] = 1'b0;
                    slot_next[idx] = free_top;
                    free_top       = int'(idx) + 1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [sfla_pkg::DOUT_W-1:0] rand_data();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return '1;
        if (pick == 1) return '0;
        return {$urandom, $urandom};
    endfunction

    // occupied slot if one turns up quickly, else any index
    function automatic logic [sfla_pkg::IDX_W-1:0] pick_live_index();
        int cand;
        for (int n = 0; n < 16 && slots_used > 0; n++) begin
            cand = $urandom_range(0, slots_used - 1);
            if (slot_live[cand]) return sfla_pkg::IDX_W'(cand);
        end
        return sfla_pkg::IDX_W'($urandom_range(0, CAPACITY - 1));
    endfunction

    task automatic send_request(sfla_pkg::t_cmd cmd, logic [sfla_pkg::IDX_W-1:0] idx,
                                logic [sfla_pkg::DOUT_W-1:0] data,
                                bit typed, sfla_pkg::t_result typed_exp);
        int                gap;
        sfla_pkg::t_result want;
        gap = no_gap ? 0 : $urandom_range(0, 11);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        <= 1'b1;
        i_command    <= cmd;
        i_slot_index <= idx;
        i_data_in    <= data;
        do @(posedge i_clk); while (busy);
        want = allocate_or_lookup(cmd, idx, data);
        pending_results.push_back(typed ? typed_exp : want);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic random_requests(int count);
        int                kind;
        sfla_pkg::t_result none;
        none = '0;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) no_gap = ($urandom_range(0, 2) == 0);
            kind = $urandom_range(0, 9);
            if (kind <= 3)
                send_request(sfla_pkg::CMD_INSERT, sfla_pkg::IDX_W'($urandom), rand_data(),
                             1'b0, none);
            else if (kind <= 5)
                send_request(sfla_pkg::CMD_REMOVE, pick_live_index(), rand_data(), 1'b0,
                             none);
            else if (kind <= 7)
                send_request(sfla_pkg::CMD_GET, pick_live_index(), rand_data(), 1'b0, none);
            else
                send_request(sfla_pkg::t_cmd'($urandom_range(0, 3)),
                             sfla_pkg::IDX_W'($urandom), rand_data(), 1'b0, none);
        end
        no_gap = 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        sfla_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d index %0d data %h",
                       o_status, o_result_index, o_data_out);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_result_index !== want.index) begin
                    $error("result_index: expected %0d, got %0d", want.index, o_result_index);
                    fail_count++;
                end
                if (o_data_out !== want.data) begin
                    $error("data_out: expected %h, got %h", want.data, o_data_out);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        sfla_pkg::t_result none;
        none         = '0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_command    = sfla_pkg::CMD_INSERT;
        i_slot_index = '0;
        i_data_in    = '0;
        fail_count   = 0;
        idle_cycles  = 0;
        no_gap       = 1'b0;
        free_top     = 0;
        slots_used   = 0;
        for (int n = 0; n < CAPACITY; n++) begin
            slot_live[n] = 1'b0;
            slot_next[n] = 0;
            slot_data[n] = '0;
        end

        directed_rows.push_back('{sfla_pkg::CMD_GET, 10'd0, 64'd0, 1'b1,
                                  '{sfla_pkg::ST_RANGE, 10'd0, 64'd0}});
        directed_rows.push_back('{sfla_pkg::CMD_REMOVE, 10'd1023, '1, 1'b1,
                                  '{sfla_pkg::ST_RANGE, 10'd1023, 64'd0}});
        directed_rows.push_back('{sfla_pkg::CMD_NONE, 10'd1023, '1, 1'b1,
                                  '{sfla_pkg::ST_OK, 10'd1023, 64'd0}});
        directed_rows.push_back('{sfla_pkg::CMD_INSERT, 10'd1023, '1, 1'b1,
                                  '{sfla_pkg::ST_OK, 10'd0, 64'd0}});
        directed_rows.push_back('{sfla_pkg::CMD_INSERT, 10'd0, 64'd0, 1'b1,
                                  '{sfla_pkg::ST_OK, 10'd1, 64'd0}});
        directed_rows.push_back('{sfla_pkg::CMD_INSERT, 10'd0, 64'h8000_0000_0000_0001, 1'b1,
                                  '{sfla_pkg::ST_OK, 10'd2, 64'd0}});
        directed_rows.push_back('{sfla_pkg::CMD_GET, 10'd0, 64'd0, 1'b1,
                                  '{sfla_pkg::ST_OK, 10'd0, '1}});
        directed_rows.push_back('{sfla_pkg::CMD_GET, 10'd1, '1, 1'b1,
                                  '{sfla_pkg::ST_OK, 10'd1, 64'd0}});
        directed_rows.push_back('{sfla_pkg::CMD_GET, 10'd2, 64'd0, 1'b1,
                                  '{sfla_pkg::ST_OK, 10'd2, 64'h8000_0000_0000_0001}});
        directed_rows.push_back('{sfla_pkg::CMD_GET, 10'd3, 64'd0, 1'b1,
                                  '{sfla_pkg::ST_RANGE, 10'd3, 64'd0}});
        directed_rows.push_back('{sfla_pkg::CMD_REMOVE, 10'd1, 64'd0, 1'b1,
                                  '{sfla_pkg::ST_OK, 10'd1, 64'd0}});
        directed_rows.push_back('{sfla_pkg::CMD_REMOVE, 10'd1, 64'd0, 1'b1,
                                  '{sfla_pkg::ST_VACANT, 10'd1, 64'd0}});
        directed_rows.push_back('{sfla_pkg::CMD_GET, 10'd1, 64'd0, 1'b1,
                                  '{sfla_pkg::ST_VACANT, 10'd1, 64'd0}});
        directed_rows.push_back('{sfla_pkg::CMD_REMOVE, 10'd0, 64'd0, 1'b1,
                                  '{sfla_pkg::ST_OK, 10'd0, 64'd0}});
        // free list now holds 0 then 1; these inserts pop it, the third appends
        directed_rows.push_back('{sfla_pkg::CMD_INSERT, 10'd7, 64'h5555_5555_5555_5555, 1'b0,
                                  none});
        directed_rows.push_back('{sfla_pkg::CMD_INSERT, 10'd7, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0,
                                  none});
        directed_rows.push_back('{sfla_pkg::CMD_INSERT, 10'd7, 64'h0123_4567_89AB_CDEF, 1'b0,
                                  none});
        directed_rows.push_back('{sfla_pkg::CMD_GET, 10'd0, 64'd0, 1'b0, none});
        directed_rows.push_back('{sfla_pkg::CMD_GET, 10'd1, 64'd0, 1'b0, none});
        directed_rows.push_back('{sfla_pkg::CMD_NONE, 10'd0, 64'd0, 1'b1,
                                  '{sfla_pkg::ST_OK, 10'd0, 64'd0}});
        directed_rows.push_back('{sfla_pkg::CMD_REMOVE, 10'd3, 64'd0, 1'b0, none});
        directed_rows.push_back('{sfla_pkg::CMD_REMOVE, 10'd2, 64'd0, 1'b0, none});
        directed_rows.push_back('{sfla_pkg::CMD_INSERT, 10'd0, '1, 1'b0, none});

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n])
            send_request(directed_rows[n].cmd, directed_rows[n].idx, directed_rows[n].data,
                         directed_rows[n].typed, directed_rows[n].exp);
        drain_results();

        random_requests(60);
        drain_results();

        // fill every slot, then work the store while it is full
        while (!(slots_used == CAPACITY && free_top == 0))
            send_request(sfla_pkg::CMD_INSERT, sfla_pkg::IDX_W'($urandom), rand_data(), 1'b0,
                         none);
        drain_results();
        send_request(sfla_pkg::CMD_INSERT, 10'd1023, '1, 1'b1,
                     '{sfla_pkg::ST_FULL, 10'd1023, 64'd0});
        send_request(sfla_pkg::CMD_GET, 10'd1023, 64'd0, 1'b0, none);
        send_request(sfla_pkg::CMD_REMOVE, 10'd1023, 64'd0, 1'b1,
                     '{sfla_pkg::ST_OK, 10'd1023, 64'd0});
        send_request(sfla_pkg::CMD_INSERT, 10'd0, '1, 1'b1,
                     '{sfla_pkg::ST_OK, 10'd1023, 64'd0});
        send_request(sfla_pkg::CMD_GET, 10'd1023, 64'd0, 1'b1,
                     '{sfla_pkg::ST_OK, 10'd1023, '1});
        random_requests(40);

        drain_results();
        repeat (6) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/sfla_pkg.sv
rtl/sfla_store.sv
rtl/sfla_ctrl.sv
rtl/slab_free_list_allocator.sv
tb/tb.sv
